### rtl/c8i_pkg.sv
`timescale 1ns / 1ps
package c8i_pkg;
  localparam int MemDepth = 4096;
  localparam int StackDepth = 16;
  localparam int ScreenWidth = 64;
  localparam int ScreenHeight = 32;
  localparam int AddrW = $clog2(MemDepth);
  localparam int SpW = $clog2(StackDepth);
  localparam int RowW = $clog2(ScreenHeight);
  localparam int ColW = $clog2(ScreenWidth);
  localparam logic [AddrW-1:0] PcResetVal = 12'h200;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_EXEC = 2'd1,
    OP_TICK = 2'd2,
    OP_ROW  = 2'd3
  } op_e;

  typedef enum logic [4:0] {
    S_IDLE, S_FETCH_HI, S_FETCH_LO, S_DECODE, S_CLEAR, S_RET_RD, S_RET_WAIT,
    S_SPR_RD, S_SPR_WAIT, S_SPR_PIX, S_SPR_DONE, S_BCD1, S_BCD2, S_BCD3,
    S_STORE, S_LOAD_RD, S_LOAD_WAIT, S_LOAD_WR, S_FINISH, S_OUT
  } state_e;

  typedef enum logic [3:0] {
    C_NONE, C_MEMWR, C_TICK, C_ROW, C_FETCH_HI, C_FETCH_LO, C_EXEC, C_CLEAR,
    C_RET_RD, C_RET_DO, C_SPR_RD, C_SPR_PIX, C_SPR_DONE, C_BCD, C_STORE, C_LOAD
  } cmd_e;

  typedef struct packed {
    cmd_e cmd;
    logic [1:0] sub;
    logic out_load;
  } ctrl_t;

  typedef struct packed {
    logic [3:0] kind;
    logic done;
  } stat_t;

  localparam logic [3:0] K_SIMPLE = 4'd0;
  localparam logic [3:0] K_CLEAR = 4'd1;
  localparam logic [3:0] K_RET = 4'd2;
  localparam logic [3:0] K_SPRITE = 4'd3;
  localparam logic [3:0] K_BCD = 4'd4;
  localparam logic [3:0] K_STORE = 4'd5;
  localparam logic [3:0] K_LOAD = 4'd6;
endpackage

### rtl/c8i_ram.sv
`timescale 1ns / 1ps
module c8i_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_q <= mem_q[raddr_i];
  end
  assign rdata_o = rdata_q;
endmodule

### rtl/c8i_ctrl.sv
`timescale 1ns / 1ps
module c8i_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [1:0]       opcode_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  input  c8i_pkg::stat_t   stat_i,
  output c8i_pkg::ctrl_t   ctrl_o
);
  c8i_pkg::state_e state_q, state_d;
  logic acc;

  assign acc = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != c8i_pkg::S_IDLE);
  assign out_valid_o = (state_q == c8i_pkg::S_OUT);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      c8i_pkg::S_IDLE: begin
        if (acc) begin
          if (c8i_pkg::op_e'(opcode_i) == c8i_pkg::OP_EXEC) state_d = c8i_pkg::S_FETCH_HI;
          else state_d = c8i_pkg::S_OUT;
        end
      end
      c8i_pkg::S_FETCH_HI: state_d = c8i_pkg::S_FETCH_LO;
      c8i_pkg::S_FETCH_LO: state_d = c8i_pkg::S_DECODE;
      c8i_pkg::S_DECODE: begin
        unique case (stat_i.kind)
          c8i_pkg::K_CLEAR: state_d = c8i_pkg::S_CLEAR;
          c8i_pkg::K_RET: state_d = c8i_pkg::S_RET_RD;
          c8i_pkg::K_SPRITE: state_d = c8i_pkg::S_SPR_RD;
          c8i_pkg::K_BCD: state_d = c8i_pkg::S_BCD1;
          c8i_pkg::K_STORE: state_d = c8i_pkg::S_STORE;
          c8i_pkg::K_LOAD: state_d = c8i_pkg::S_LOAD_RD;
          default: state_d = c8i_pkg::S_FINISH;
        endcase
      end
      c8i_pkg::S_CLEAR: if (stat_i.done) state_d = c8i_pkg::S_FINISH;
      c8i_pkg::S_RET_RD: state_d = c8i_pkg::S_RET_WAIT;
      c8i_pkg::S_RET_WAIT: state_d = c8i_pkg::S_FINISH;
      c8i_pkg::S_SPR_RD: state_d = stat_i.done ? c8i_pkg::S_SPR_DONE : c8i_pkg::S_SPR_WAIT;
      c8i_pkg::S_SPR_WAIT: state_d = c8i_pkg::S_SPR_PIX;
      c8i_pkg::S_SPR_PIX: if (stat_i.done) state_d = c8i_pkg::S_SPR_RD;
      c8i_pkg::S_SPR_DONE: state_d = c8i_pkg::S_FINISH;
      c8i_pkg::S_BCD1: state_d = c8i_pkg::S_BCD2;
      c8i_pkg::S_BCD2: state_d = c8i_pkg::S_BCD3;
      c8i_pkg::S_BCD3: state_d = c8i_pkg::S_FINISH;
      c8i_pkg::S_STORE: if (stat_i.done) state_d = c8i_pkg::S_FINISH;
      c8i_pkg::S_LOAD_RD: state_d = c8i_pkg::S_LOAD_WAIT;
      c8i_pkg::S_LOAD_WAIT: state_d = c8i_pkg::S_LOAD_WR;
      c8i_pkg::S_LOAD_WR: state_d = stat_i.done ? c8i_pkg::S_FINISH : c8i_pkg::S_LOAD_RD;
      c8i_pkg::S_FINISH: state_d = c8i_pkg::S_OUT;
      c8i_pkg::S_OUT: if (!out_stall_i) state_d = c8i_pkg::S_IDLE;
      default: state_d = c8i_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o = '0;
    ctrl_o.cmd = c8i_pkg::C_NONE;
    unique case (state_q)
      c8i_pkg::S_IDLE: begin
        if (acc) begin
          ctrl_o.out_load = 1'b1;
          unique case (c8i_pkg::op_e'(opcode_i))
            c8i_pkg::OP_LOAD: ctrl_o.cmd = c8i_pkg::C_MEMWR;
            c8i_pkg::OP_TICK: ctrl_o.cmd = c8i_pkg::C_TICK;
            c8i_pkg::OP_ROW: ctrl_o.cmd = c8i_pkg::C_ROW;
            default: ctrl_o.cmd = c8i_pkg::C_NONE;
          endcase
        end
      end
      c8i_pkg::S_FETCH_HI: ctrl_o.cmd = c8i_pkg::C_FETCH_HI;
      c8i_pkg::S_FETCH_LO: ctrl_o.cmd = c8i_pkg::C_FETCH_LO;
      c8i_pkg::S_DECODE: ctrl_o.cmd = c8i_pkg::C_EXEC;
      c8i_pkg::S_CLEAR: ctrl_o.cmd = c8i_pkg::C_CLEAR;
      c8i_pkg::S_RET_RD: ctrl_o.cmd = c8i_pkg::C_RET_RD;
      c8i_pkg::S_RET_WAIT: ctrl_o.cmd = c8i_pkg::C_RET_DO;
      c8i_pkg::S_SPR_RD: ctrl_o.cmd = c8i_pkg::C_SPR_RD;
      // keep the sprite address on the read port so the byte stays valid
      c8i_pkg::S_SPR_WAIT: ctrl_o.cmd = c8i_pkg::C_SPR_RD;
      c8i_pkg::S_SPR_PIX: ctrl_o.cmd = c8i_pkg::C_SPR_PIX;
      c8i_pkg::S_SPR_DONE: ctrl_o.cmd = c8i_pkg::C_SPR_DONE;
      c8i_pkg::S_BCD1: begin ctrl_o.cmd = c8i_pkg::C_BCD; ctrl_o.sub = 2'd0; end
      c8i_pkg::S_BCD2: begin ctrl_o.cmd = c8i_pkg::C_BCD; ctrl_o.sub = 2'd1; end
      c8i_pkg::S_BCD3: begin ctrl_o.cmd = c8i_pkg::C_BCD; ctrl_o.sub = 2'd2; end
      c8i_pkg::S_STORE: ctrl_o.cmd = c8i_pkg::C_STORE;
      c8i_pkg::S_LOAD_RD: ctrl_o.cmd = c8i_pkg::C_SPR_RD;
      c8i_pkg::S_LOAD_WAIT: ctrl_o.cmd = c8i_pkg::C_SPR_RD;
      c8i_pkg::S_LOAD_WR: ctrl_o.cmd = c8i_pkg::C_LOAD;
      default: ctrl_o.cmd = c8i_pkg::C_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= c8i_pkg::S_IDLE;
    else state_q <= state_d;
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o) else $error("result dropped");
  a_no_acc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != c8i_pkg::S_IDLE) |-> !acc) else $error("accept while busy");
  a_fetch_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == c8i_pkg::S_FETCH_HI) |=> (state_q == c8i_pkg::S_FETCH_LO))
    else $error("fetch order");
endmodule

### rtl/c8i_dp.sv
`timescale 1ns / 1ps
module c8i_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [11:0]                   cfg_wdata_i,
  input  c8i_pkg::ctrl_t                ctrl_i,
  output c8i_pkg::stat_t                stat_o,
  input  logic [11:0]                   load_address_i,
  input  logic [7:0]                    load_byte_i,
  input  logic [15:0]                   key_states_i,
  input  logic [7:0]                    random_byte_i,
  input  logic [4:0]                    row_select_i,
  output logic [11:0]                   program_counter_o,
  output logic [63:0]                   display_row_o,
  output logic                          screen_changed_o,
  output logic                          waiting_for_key_o
,
  output logic                          sound_on_o
);
  localparam int AW = c8i_pkg::AddrW;
  localparam int SW = c8i_pkg::SpW;
  localparam int RW = c8i_pkg::RowW;
  localparam int CW = c8i_pkg::ColW;

  logic [AW-1:0] pc_q, pc_d, idx_q, idx_d;
  logic [7:0] v_q [16];
  logic [7:0] v_d [16];
  logic [SW-1:0] sp_q, sp_d;
  logic [7:0] dt_q, dt_d, st_q, st_d;
  logic [15:0] ir_q, ir_d;
  logic [3:0] cnt_q, cnt_d;
  logic [2:0] pix_q, pix_d;
  logic [7:0] bits_q, bits_d;
  logic hit_q, hit_d;
  logic [11:0] pc_o_q, pc_o_d;
  logic [63:0] row_o_q, row_o_d;
  logic chg_q, chg_d, wait_q, wait_d;
  logic [15:0] keys_q;
  logic [7:0] rnd_q;

  logic [63:0] fb_q [c8i_pkg::ScreenHeight];
  logic [63:0] fb_wdata;
  logic [RW-1:0] fb_wrow;
  logic fb_we, fb_clr;

  logic mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0] mem_wdata, mem_rdata;
  logic stk_we;
  logic [SW-1:0] stk_waddr, stk_raddr;
  logic [AW-1:0] stk_rdata;

  c8i_ram #(.Width(8), .Depth(c8i_pkg::MemDepth)) u_mem (
    .clk_i, .we_i(mem_we), .waddr_i(mem_waddr), .wdata_i(mem_wdata),
    .raddr_i(mem_raddr), .rdata_o(mem_rdata));
  c8i_ram #(.Width(AW), .Depth(c8i_pkg::StackDepth)) u_stk (
    .clk_i, .we_i(stk_we), .waddr_i(stk_waddr), .wdata_i(pc_q),
    .raddr_i(stk_raddr), .rdata_o(stk_rdata));

  logic [3:0] x, y, n;
  logic [7:0] nn, vx, vy;
  logic [8:0] sum9;
  logic [12:0] isum;
  logic [10:0] pidx;
  logic [63:0] pbit;
  logic [7:0] dig;
  logic [7:0] vx_div10;
  logic [15:0] mul10;

  assign x = ir_q[11:8];
  assign y = ir_q[7:4];
  assign n = ir_q[3:0];
  assign nn = ir_q[7:0];
  assign vx = v_q[x];
  assign vy = v_q[y];
  assign sum9 = {1'b0, vx} + {1'b0, vy};
  assign isum = {1'b0, idx_q} + {5'd0, vx};
  // x coordinate plus 64 * y coordinate, wrapped to the screen
  assign pidx = 11'({3'd0, vx} + {8'd0, pix_q}) +
                11'({{3'd0, vy} + {7'd0, cnt_q}, 6'd0});
  assign pbit = 64'h8000_0000_0000_0000 >> pidx[CW-1:0];
  // divide by ten through a reciprocal, exact for 8-bit values
  assign mul10 = {8'd0, vx} * 16'd205;
  assign vx_div10 = 8'(mul10 >> 11);

  always_comb begin
    unique case (ctrl_i.sub)
      2'd0: dig = 8'(vx_div10 >= 8'd10 ? (vx_div10 >= 8'd20 ? 8'd2 : 8'd1) : 8'd0);
      2'd1: dig = 8'(vx_div10 - (vx_div10 >= 8'd20 ? 8'd20 :
                                 (vx_div10 >= 8'd10 ? 8'd10 : 8'd0)));
      default: dig = 8'(vx - 8'(vx_div10 * 8'd10));
    endcase
  end

  always_comb begin
    stat_o.done = 1'b0;
    stat_o.kind = c8i_pkg::K_SIMPLE;
    unique case (ir_q[15:12])
      4'h0: begin
        if (ir_q == 16'h00E0) stat_o.kind = c8i_pkg::K_CLEAR;
        else if (ir_q == 16'h00EE) stat_o.kind = c8i_pkg::K_RET;
      end
      4'hD: stat_o.kind = c8i_pkg::K_SPRITE;
      4'hF: begin
        if (nn == 8'h33) stat_o.kind = c8i_pkg::K_BCD;
        else if (nn == 8'h55) stat_o.kind = c8i_pkg::K_STORE;
        else if (nn == 8'h65) stat_o.kind = c8i_pkg::K_LOAD;
      end
      default: stat_o.kind = c8i_pkg::K_SIMPLE;
    endcase
    unique case (ctrl_i.cmd)
      c8i_pkg::C_CLEAR: stat_o.done = (cnt_q == 4'hF);
      c8i_pkg::C_SPR_RD: stat_o.done = (cnt_q == n);
      c8i_pkg::C_SPR_PIX: stat_o.done = (pix_q == 3'd7);
      c8i_pkg::C_STORE, c8i_pkg::C_LOAD: stat_o.done = (cnt_q == x);
      default: stat_o.done = 1'b0;
    endcase
  end

  always_comb begin
    pc_d = pc_q; idx_d = idx_q; sp_d = sp_q; dt_d = dt_q; st_d = st_q;
    ir_d = ir_q; cnt_d = cnt_q; pix_d = pix_q; bits_d = bits_q; hit_d = hit_q;
    pc_o_d = pc_o_q; row_o_d = row_o_q; chg_d = chg_q; wait_d = wait_q;
    for (int k = 0; k < 16; k++) v_d[k] = v_q[k];
    mem_we = 1'b0; mem_waddr = load_address_i; mem_wdata = load_byte_i;
    mem_raddr = pc_q;
    stk_we = 1'b0; stk_waddr = sp_q; stk_raddr = sp_q - 1'b1;
    fb_we = 1'b0; fb_clr = 1'b0; fb_wrow = pidx[10:CW]; fb_wdata = '0;

    if (ctrl_i.out_load) begin
      row_o_d = '0; chg_d = 1'b0; wait_d = 1'b0;
    end
    unique case (ctrl_i.cmd)
      c8i_pkg::C_MEMWR: mem_we = 1'b1;
      c8i_pkg::C_TICK: begin
        if (dt_q != 8'd0) dt_d = dt_q - 8'd1;
        if (st_q != 8'd0) st_d = st_q - 8'd1;
      end
      c8i_pkg::C_ROW: row_o_d = fb_q[row_select_i];
      // high byte arrives from the read issued at accept, low byte is read next
      c8i_pkg::C_FETCH_HI: begin
        mem_raddr = pc_q + 1'b1;
        ir_d[15:8] = mem_rdata;
      end
      c8i_pkg::C_FETCH_LO: ir_d[7:0] = mem_rdata;
      c8i_pkg::C_EXEC: begin
        cnt_d = '0; pix_d = '0; hit_d = 1'b0;
        unique case (ir_q[15:12])
          4'h0: begin
            if (ir_q == 16'h00E0) chg_d = 1'b1;
            if (ir_q != 16'h00EE) pc_d = pc_q + 12'd2;
            else sp_d = sp_q - 1'b1;
          end
          4'h1: pc_d = ir_q[11:0];
          4'h2: begin
            stk_we = 1'b1; sp_d = sp_q + 1'b1; pc_d = ir_q[11:0];
          end
          4'h3: pc_d = pc_q + ((vx == nn) ? 12'd4 : 12'd2);
          4'h4: pc_d = pc_q + ((vx != nn) ? 12'd4 : 12'd2);
          4'h5: pc_d = pc_q + ((vx == vy) ? 12'd4 : 12'd2);
          4'h6: begin v_d[x] = nn; pc_d = pc_q + 12'd2; end
          4'h7: begin v_d[x] = vx + nn; pc_d = pc_q + 12'd2; end
          4'h8: begin
            pc_d = pc_q + 12'd2;
            unique case (n)
              4'h0: v_d[x] = vy;
              4'h1: v_d[x] = vx | vy;
              4'h2: v_d[x] = vx & vy;
              4'h3: v_d[x] = vx ^ vy;
              4'h4: begin v_d[x] = sum9[7:0]; v_d[15] = {7'd0, sum9[8]}; end
              4'h5: begin v_d[x] = vx - vy; v_d[15] = {7'd0, vx >= vy}; end
              4'h6: begin v_d[x] = vx >> 1; v_d[15] = {7'd0, vx[0]}; end
              4'h7: begin v_d[x] = vy - vx; v_d[15] = {7'd0, vy >= vx}; end
              4'hE: begin v_d[x] = vx << 1; v_d[15] = {7'd0, vx[7]}; end
              default: ;
            endcase
          end
          4'h9: pc_d = pc_q + ((vx != vy) ? 12'd4 : 12'd2);
          4'hA: begin idx_d = ir_q[11:0]; pc_d = pc_q + 12'd2; end
          4'hB: pc_d = ir_q[11:0] + {4'd0, v_q[0]};
          4'hC: begin v_d[x] = rnd_q & nn; pc_d = pc_q + 12'd2; end
          4'hD: begin chg_d = 1'b1; pc_d = pc_q + 12'd2; end
          4'hE: begin
            if (nn == 8'h9E) pc_d = pc_q + (keys_q[vx[3:0]] ? 12'd4 : 12'd2);
            else if (nn == 8'hA1) pc_d = pc_q + (keys_q[vx[3:0]] ? 12'd2 : 12'd4);
            else pc_d = pc_q + 12'd2;
          end
          default: begin
            pc_d = pc_q + 12'd2;
            unique case (nn)
              8'h07: v_d[x] = dt_q;
              8'h0A: begin
                if (keys_q == 16'd0) begin
                  wait_d = 1'b1; pc_d = pc_q;
                end else begin
                  for (int k = 15; k >= 0; k--)
                    if (keys_q[k]) v_d[x] = 8'(k);
                end
              end
              8'h15: dt_d = vx;
              8'h18: st_d = vx;
              8'h1E: begin idx_d = isum[11:0]; v_d[15] = {7'd0, isum[12]}; end
              8'h29: idx_d = 12'({4'd0, vx} * 12'd5);
              default: ;
            endcase
          end
        endcase
      end
      c8i_pkg::C_CLEAR: begin
        fb_clr = 1'b1; cnt_d = cnt_q + 1'b1;
      end
      // stack pointer already points at the popped entry
      c8i_pkg::C_RET_RD: stk_raddr = sp_q;
      c8i_pkg::C_RET_DO: pc_d = stk_rdata + 12'd2;
      c8i_pkg::C_SPR_RD: begin
        mem_raddr = idx_q + {8'd0, cnt_q};
        pix_d = '0;
      end
      c8i_pkg::C_SPR_PIX: begin
        if (pix_q == 3'd0 ? mem_rdata[7] : bits_q[7]) begin
          fb_we = 1'b1;
          fb_wdata = fb_q[pidx[10:CW]] ^ pbit;
          if ((fb_q[pidx[10:CW]] & pbit) != 64'd0) hit_d = 1'b1;
        end
        bits_d = (pix_q == 3'd0 ? mem_rdata : bits_q) << 1;
        pix_d = pix_q + 1'b1;
        if (pix_q == 3'd7) cnt_d = cnt_q + 1'b1;
      end
      c8i_pkg::C_SPR_DONE: v_d[15] = {7'd0, hit_q};
      c8i_pkg::C_BCD: begin
        mem_we = 1'b1;
        mem_waddr = idx_q + {10'd0, ctrl_i.sub};
        mem_wdata = dig;
      end
      c8i_pkg::C_STORE: begin
        mem_we = 1'b1;
        mem_waddr = idx_q + {8'd0, cnt_q};
        mem_wdata = v_q[cnt_q];
        cnt_d = cnt_q + 1'b1;
      end
      c8i_pkg::C_LOAD: begin
        v_d[cnt_q] = mem_rdata;
        cnt_d = cnt_q + 1'b1;
      end
      default: ;
    endcase
    if (ctrl_i.cmd == c8i_pkg::C_FETCH_HI || ctrl_i.out_load) pc_o_d = pc_d;
    if (ctrl_i.cmd == c8i_pkg::C_EXEC || ctrl_i.cmd == c8i_pkg::C_RET_DO) pc_o_d = pc_d;
    if (ctrl_i.cmd == c8i_pkg::C_FETCH_LO) pc_o_d = pc_q;
    if (cfg_we_i) pc_d = cfg_wdata_i;
  end

  always_ff @(posedge clk_i) begin
    ir_q <= ir_d;
    bits_q <= bits_d;
    row_o_q <= row_o_d;
    // key and random fields are only valid in the accept cycle
    if (ctrl_i.out_load) begin
      keys_q <= key_states_i;
      rnd_q <= random_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= c8i_pkg::PcResetVal; idx_q <= '0; sp_q <= '0; dt_q <= '0; st_q <= '0;
      cnt_q <= '0; pix_q <= '0; hit_q <= 1'b0;
      pc_o_q <= '0; chg_q <= 1'b0; wait_q <= 1'b0;
      for (int k = 0; k < 16; k++) v_q[k] <= '0;
      for (int k = 0; k < c8i_pkg::ScreenHeight; k++) fb_q[k] <= '0;
    end else begin
      pc_q <= pc_d; idx_q <= idx_d; sp_q <= sp_d; dt_q <= dt_d; st_q <= st_d;
      cnt_q <= cnt_d; pix_q <= pix_d; hit_q <= hit_d;
      pc_o_q <= pc_o_d; chg_q <= chg_d; wait_q <= wait_d;
      for (int k = 0; k < 16; k++) v_q[k] <= v_d[k];
      // clear two rows per step over sixteen steps
      if (fb_clr) begin
        fb_q[{cnt_q, 1'b0}] <= '0;
        fb_q[{cnt_q, 1'b1}] <= '0;
      end else if (fb_we) fb_q[fb_wrow] <= fb_wdata;
    end
  end

  assign program_counter_o = pc_o_q;
  assign display_row_o = row_o_q;
  assign screen_changed_o = chg_q;
  assign waiting_for_key_o = wait_q;
  assign sound_on_o = (st_q != 8'd0);

  a_wait_no_chg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wait_q && chg_q)) else $error("wait with screen change");
  a_tick_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.cmd == c8i_pkg::C_TICK && st_q != 8'd0 && !cfg_we_i) |=> st_q == $past(st_q) - 8'd1)
    else $error("sound timer");
  a_clr_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.cmd == c8i_pkg::C_CLEAR && cnt_q == 4'hF) |=> fb_q[0] == 64'd0)
    else $error("clear incomplete");
endmodule

### rtl/chip8_interpreter_core_unit.sv
`timescale 1ns / 1ps
// chip8 interpreter core
// input channel: in_valid_i / in_stall_o with opcode, load, key, random and row fields
// output channel: out_valid_o / out_stall_i, one result beat per input beat
// op 0 writes a memory byte, op 1 fetches and runs one instruction at the pc,
// op 2 ticks the timers, op 3 returns one framebuffer row
// op 1 fetches both instruction bytes, decodes, then executes; 00EE reads the return
// stack before setting the pc, FX33 writes its three digits in turn, 00E0 clears
// the screen in sixteen two-row clear steps, DXYN reads each sprite row and draws
// it one pixel per cycle, FX65 reads and loads one register at a time and FX55
// stores one register at a time; one registered memory read is issued at a time
// one item at a time: the next beat is taken only after the result beat leaves
// reset: registers, timers, stack pointer and framebuffer clear; pc is 0x200
// memory and return stack are undefined until written
// cfg_we_i loads program start into the pc at once
// a stalled result holds its value until out_stall_i drops
module chip8_interpreter_core_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [11:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [11:0] load_address_i,
  input  logic [7:0]  load_byte_i,
  input  logic [15:0] key_states_i,
  input  logic [7:0]  random_byte_i,
  input  logic [4:0]  row_select_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [11:0] program_counter_o,
  output logic [63:0] display_row_o,
  output logic        screen_changed_o,
  output logic        waiting_for_key_o,
  output logic        sound_on_o
);
  c8i_pkg::ctrl_t ctrl;
  c8i_pkg::stat_t stat;

  c8i_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .opcode_i,
    .out_valid_o, .out_stall_i, .stat_i(stat), .ctrl_o(ctrl));

  c8i_dp u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .ctrl_i(ctrl), .stat_o(stat),
    .load_address_i, .load_byte_i, .key_states_i, .random_byte_i, .row_select_i,
    .program_counter_o, .display_row_o, .screen_changed_o, .waiting_for_key_o,
    .sound_on_o);
endmodule
